[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every clock edge outside reset.
`define RPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");

// Checks a condition on every clock edge, reset included.
`define RPS_ASSERT_ALWAYS(label, clk, expr) \
    label: assert property (@(posedge clk) expr) \
        else $error("assertion failed: label");

`endif

[hdl/rps_pkg.sv]
// Package with the constants, types and state codes of the remainder prefix sum block.
package rps_pkg;

    localparam int VALUE_BITS  = 20;
    localparam int TABLE_DEPTH = 2048;
    localparam int IN_BITS     = 20;
    localparam int OUT_BITS    = 40;

    localparam int BP_AW   = $clog2(TABLE_DEPTH);
    localparam int PS_AW   = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W   = $clog2(TABLE_DEPTH) + 1;
    localparam int IDX_W   = (VALUE_BITS + 1) / 2 + 1;
    localparam int PROD_W  = 2 * VALUE_BITS + 1;
    localparam int DCNT_W  = $clog2(VALUE_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_B_INIT,
        S_B_INIT2,
        S_B_UP,
        S_B_DOWN,
        S_B_DIVI,
        S_PUSH,
        S_BS_D1,
        S_BS_D2,
        S_BS_MUL,
        S_BS_ACC,
        S_Q_START,
        S_Q_CMP,
        S_Q_WAIT,
        S_Q_RD,
        S_Q_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_UP,
        PH_DOWN,
        PH_QUERY
    } t_phase;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [VALUE_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [VALUE_BITS-1:0] remainder;
    } t_div_rsp;

    typedef struct packed {
        logic                  bp_we;
        logic [BP_AW-1:0]      bp_waddr;
        logic [VALUE_BITS-1:0] bp_wdata;
        logic [BP_AW-1:0]      bp_raddr;
        logic                  ps_we;
        logic [PS_AW-1:0]      ps_waddr;
        logic [OUT_BITS-1:0]   ps_wdata;
        logic [PS_AW-1:0]      ps_raddr;
    } t_tbl_req;

    typedef struct packed {
        logic [VALUE_BITS-1:0] bp_rdata;
        logic [OUT_BITS-1:0]   ps_rdata;
    } t_tbl_rsp;

endpackage

[hdl/rps_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module rps_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rps_pkg::t_div_req i_req,
    output rps_pkg::t_div_rsp o_rsp
);

    localparam int VB = rps_pkg::VALUE_BITS;

    logic [VB:0]                  r_rem, n_rem;
    logic [VB-1:0]                r_quo, n_quo;
    logic [VB-1:0]                r_dvs;
    logic [rps_pkg::DCNT_W-1:0]   r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [VB:0]                  w_trial;

    always_comb begin
        w_trial = {r_rem[VB-1:0], r_quo[VB-1]};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = w_trial - {1'b0, r_dvs};
            n_quo = {r_quo[VB-2:0], 1'b1};
        end else begin
            n_rem = w_trial;
            n_quo = {r_quo[VB-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= rps_pkg::DCNT_W'(VB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rps_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[VB-1:0];

endmodule

[hdl/rps_tables.sv]
// Breakpoint and prefix sum memories, one write and one registered read port each.
module rps_tables (
    input  logic              i_clk,
    input  rps_pkg::t_tbl_req i_req,
    output rps_pkg::t_tbl_rsp o_rsp
);

    logic [rps_pkg::VALUE_BITS-1:0] r_bp_mem [rps_pkg::TABLE_DEPTH];
    logic [rps_pkg::OUT_BITS-1:0]   r_ps_mem [rps_pkg::TABLE_DEPTH + 1];
    logic [rps_pkg::VALUE_BITS-1:0] r_bp_rd;
    logic [rps_pkg::OUT_BITS-1:0]   r_ps_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.bp_we) begin
            r_bp_mem[i_req.bp_waddr] <= i_req.bp_wdata;
        end
        r_bp_rd <= r_bp_mem[i_req.bp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ps_we) begin
            r_ps_mem[i_req.ps_waddr] <= i_req.ps_wdata;
        end
        r_ps_rd <= r_ps_mem[i_req.ps_raddr];
    end

    assign o_rsp.bp_rdata = r_bp_rd;
    assign o_rsp.ps_rdata = r_ps_rd;

endmodule

[hdl/remainder_prefix_sum.sv]
// With valid tables a query runs a binary search over the breakpoints and then up to two
// divisions; the block takes one query word at a time.
// The first query after reset or a modulus write first rebuilds both tables: two
// divisions per ascending and three per descending breakpoint, for up to about 2047
// breakpoints.
// Reset is synchronous and active low; it sets the modulus to 1 and marks the tables
// stale. Table contents are not cleared; every entry is written before it is read.
module remainder_prefix_sum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [19:0]                  i_modulus,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rps_pkg::IN_BITS-1:0]  i_query_bound,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rps_pkg::OUT_BITS-1:0] o_remainder_sum
);

    localparam int VB = rps_pkg::VALUE_BITS;
    localparam int OW = rps_pkg::OUT_BITS;
    localparam int CW = rps_pkg::CNT_W;
    localparam int IW = rps_pkg::IDX_W;
    localparam int PW = rps_pkg::PROD_W;

    rps_pkg::t_state  r_state, n_state;
    rps_pkg::t_phase  r_phase, n_phase;
    rps_pkg::t_div_req w_div_req;
    rps_pkg::t_div_rsp w_div_rsp;
    rps_pkg::t_tbl_req w_tbl_req;
    rps_pkg::t_tbl_rsp w_tbl_rsp;

    logic [VB-1:0] r_n, n_n;
    logic          r_valid, n_valid;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_s, n_s;
    logic [VB-1:0] r_v, n_v;
    logic [VB-1:0] r_prev, n_prev;
    logic [OW-1:0] r_prefix, n_prefix;
    logic [VB-1:0] r_r, n_r;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [VB-1:0] r_bl, n_bl;
    logic [VB-1:0] r_bh, n_bh;
    logic [VB-1:0] r_ma, n_ma;
    logic [VB-1:0] r_mb, n_mb;
    logic [PW-1:0] r_prod, n_prod;
    logic [OW-1:0] r_base, n_base;
    logic [OW-1:0] r_res, n_res;
    logic          r_ov, n_ov;
    logic [OW-1:0] r_out, n_out;

    logic [2*IW-1:0] w_sq;
    logic [VB:0]     w_lo_ext;
    logic [VB:0]     w_dl;
    logic [CW-1:0]   w_mid;
    logic [OW-1:0]   w_add;

    rps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    rps_tables u_tables (
        .i_clk (i_clk),
        .i_req (w_tbl_req),
        .o_rsp (w_tbl_rsp)
    );

    assign w_sq     = r_i * r_i;
    assign w_lo_ext = {1'b0, r_prev} + 1'b1;
    assign w_dl     = {1'b0, w_tbl_rsp.bp_rdata} + 1'b1;
    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_add    = OW'(r_prod >> 1);

    assign o_cfg_ready     = 1'b1;
    assign o_in_ready      = (r_state == rps_pkg::S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_remainder_sum = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rps_pkg::S_IDLE;
            r_phase <= rps_pkg::PH_UP;
            r_n     <= VB'(1);
            r_valid <= 1'b0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_n     <= n_n;
            r_valid <= n_valid;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_s      <= n_s;
        r_v      <= n_v;
        r_prev   <= n_prev;
        r_prefix <= n_prefix;
        r_r      <= n_r;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_bl     <= n_bl;
        r_bh     <= n_bh;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_prod   <= n_prod;
        r_base   <= n_base;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_n      = r_n;
        n_valid  = r_valid;
        n_count  = r_count;
        n_i      = r_i;
        n_s      = r_s;
        n_v      = r_v;
        n_prev   = r_prev;
        n_prefix = r_prefix;
        n_r      = r_r;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_bl     = r_bl;
        n_bh     = r_bh;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_prod   = r_prod;
        n_base   = r_base;
        n_res    = r_res;
        n_ov     = r_ov;
        n_out    = r_out;

        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_n;
        w_div_req.divisor  = r_bl;

        w_tbl_req.bp_we    = 1'b0;
        w_tbl_req.bp_waddr = r_count[rps_pkg::BP_AW-1:0];
        w_tbl_req.bp_wdata = r_v;
        w_tbl_req.bp_raddr = r_mid[rps_pkg::BP_AW-1:0];
        w_tbl_req.ps_we    = 1'b0;
        w_tbl_req.ps_waddr = rps_pkg::PS_AW'(r_count + 1'b1);
        w_tbl_req.ps_wdata = r_prefix + w_add;
        w_tbl_req.ps_raddr = rps_pkg::PS_AW'(r_lo);

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        if (i_cfg_valid) begin
            n_n     = VB'(i_modulus);
            n_valid = 1'b0;
        end

        unique case (r_state)
            rps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_r     = VB'(i_query_bound);
                    n_state = r_valid ? rps_pkg::S_Q_START : rps_pkg::S_B_INIT;
                end
            end
            rps_pkg::S_B_INIT: begin
                w_tbl_req.bp_we    = 1'b1;
                w_tbl_req.bp_waddr = '0;
                w_tbl_req.bp_wdata = '0;
                w_tbl_req.ps_we    = 1'b1;
                w_tbl_req.ps_waddr = '0;
                w_tbl_req.ps_wdata = '0;
                n_count  = CW'(1);
                n_i      = IW'(1);
                n_s      = '0;
                n_prev   = '0;
                n_prefix = '0;
                n_state  = rps_pkg::S_B_INIT2;
            end
            rps_pkg::S_B_INIT2: begin
                w_tbl_req.ps_we    = 1'b1;
                w_tbl_req.ps_waddr = rps_pkg::PS_AW'(1);
                w_tbl_req.ps_wdata = '0;
                n_state = rps_pkg::S_B_UP;
            end
            rps_pkg::S_B_UP: begin
                // Ascending breakpoints 1..floor(sqrt n).
                if (w_sq <= (2*IW)'(r_n)) begin
                    n_v     = VB'(r_i);
                    n_s     = r_i;
                    n_i     = r_i + 1'b1;
                    n_phase = rps_pkg::PH_UP;
                    n_state = rps_pkg::S_PUSH;
                end else begin
                    n_i     = r_s;
                    n_state = rps_pkg::S_B_DOWN;
                end
            end
            rps_pkg::S_B_DOWN: begin
                // Descending i gives ascending n/i.
                if (r_i == '0) begin
                    n_valid = 1'b1;
                    n_state = rps_pkg::S_Q_START;
                end else if (w_sq < (2*IW)'(r_n)) begin
                    w_div_req.start   = 1'b1;
                    w_div_req.divisor = VB'(r_i);
                    n_state = rps_pkg::S_B_DIVI;
                end else begin
                    n_i = r_i - 1'b1;
                end
            end
            rps_pkg::S_B_DIVI: begin
                if (w_div_rsp.done) begin
                    n_v     = w_div_rsp.quotient;
                    n_i     = r_i - 1'b1;
                    n_phase = rps_pkg::PH_DOWN;
                    n_state = rps_pkg::S_PUSH;
                end
            end
            rps_pkg::S_PUSH: begin
                if (r_count >= CW'(rps_pkg::TABLE_DEPTH)) begin
                    n_state = (r_phase == rps_pkg::PH_UP) ? rps_pkg::S_B_UP
                                                          : rps_pkg::S_B_DOWN;
                end else begin
                    w_tbl_req.bp_we = 1'b1;
                    n_bl = VB'(w_lo_ext);
                    n_bh = r_v;
                    if ({1'b0, r_v} >= w_lo_ext) begin
                        w_div_req.start   = 1'b1;
                        w_div_req.divisor = VB'(w_lo_ext);
                        n_state = rps_pkg::S_BS_D1;
                    end else begin
                        // A repeated breakpoint closes an empty block.
                        n_prod  = '0;
                        n_state = rps_pkg::S_BS_ACC;
                    end
                end
            end
            rps_pkg::S_BS_D1: begin
                if (w_div_rsp.done) begin
                    n_ma = w_div_rsp.remainder;
                    w_div_req.start   = 1'b1;
                    w_div_req.divisor = r_bh;
                    n_state = rps_pkg::S_BS_D2;
                end
            end
            rps_pkg::S_BS_D2: begin
                if (w_div_rsp.done) begin
                    n_mb    = w_div_rsp.remainder;
                    n_state = rps_pkg::S_BS_MUL;
                end
            end
            rps_pkg::S_BS_MUL: begin
                n_prod  = PW'(({1'b0, r_ma} + {1'b0, r_mb}) * (r_bh - r_bl + 1'b1));
                n_state = rps_pkg::S_BS_ACC;
            end
            rps_pkg::S_BS_ACC: begin
                if (r_phase == rps_pkg::PH_QUERY) begin
                    n_res   = r_base + w_add;
                    n_state = rps_pkg::S_Q_OUT;
                end else begin
                    w_tbl_req.ps_we = 1'b1;
                    n_prefix = r_prefix + w_add;
                    n_count  = r_count + 1'b1;
                    n_prev   = r_bh;
                    n_state  = (r_phase == rps_pkg::PH_UP) ? rps_pkg::S_B_UP
                                                           : rps_pkg::S_B_DOWN;
                end
            end
            rps_pkg::S_Q_START: begin
                if (r_r == '0) begin
                    n_res   = '0;
                    n_state = rps_pkg::S_Q_OUT;
                end else begin
                    n_lo    = CW'(1);
                    n_hi    = r_count;
                    n_state = rps_pkg::S_Q_CMP;
                end
            end
            rps_pkg::S_Q_CMP: begin
                if (r_lo < r_hi) begin
                    w_tbl_req.bp_raddr = w_mid[rps_pkg::BP_AW-1:0];
                    n_mid   = w_mid;
                    n_state = rps_pkg::S_Q_WAIT;
                end else begin
                    w_tbl_req.bp_raddr = rps_pkg::BP_AW'(r_lo - 1'b1);
                    w_tbl_req.ps_raddr = rps_pkg::PS_AW'(r_lo);
                    n_state = rps_pkg::S_Q_RD;
                end
            end
            rps_pkg::S_Q_WAIT: begin
                if (w_tbl_rsp.bp_rdata <= r_r) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = rps_pkg::S_Q_CMP;
            end
            rps_pkg::S_Q_RD: begin
                n_base  = w_tbl_rsp.ps_rdata;
                n_phase = rps_pkg::PH_QUERY;
                n_bl    = VB'(w_dl);
                n_bh    = r_r;
                if ({1'b0, r_r} >= w_dl) begin
                    w_div_req.start   = 1'b1;
                    w_div_req.divisor = VB'(w_dl);
                    n_state = rps_pkg::S_BS_D1;
                end else begin
                    n_prod  = '0;
                    n_state = rps_pkg::S_BS_ACC;
                end
            end
            rps_pkg::S_Q_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = rps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hdl/rps_checker.sv]
// Port-level checker for the remainder prefix sum block, bound to the top level.
`include "assert_macros.svh"

module rps_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_cfg_ready,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [rps_pkg::OUT_BITS-1:0] o_remainder_sum
);

    // A waiting result word stays offered and unchanged.
    `RPS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `RPS_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_remainder_sum))
    // Only one query is in flight: accepting a word closes the input.
    `RPS_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)
    // Configuration writes are never stalled.
    `RPS_ASSERT_ALWAYS(a_cfg_ready, i_clk, o_cfg_ready)

endmodule

bind remainder_prefix_sum rps_checker u_rps_checker (.*);
